// ===== design/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
// Used by every module of the block; depends on nothing else.
package rhc_pkg;

    localparam int COMP_BITS       = 8;
    localparam int FRAC_BITS       = 16;
    // Quotient bits resolved by each divider stage.
    localparam int DIV_STEP_BITS   = 4;
    localparam int DIV_STAGES      = FRAC_BITS / DIV_STEP_BITS;
    // Six times the largest delta needs three more bits than a component.
    localparam int HUE_BITS        = COMP_BITS + 3;

    typedef struct packed {
        logic [COMP_BITS-1:0] red_level;
        logic [COMP_BITS-1:0] green_level;
        logic [COMP_BITS-1:0] blue_level;
    } t_rgb_in;

    typedef struct packed {
        logic [FRAC_BITS-1:0] hue_turn;
        logic [FRAC_BITS-1:0] saturation_frac;
        logic [COMP_BITS-1:0] value_level;
        logic                 is_gray;
    } t_hsv_out;

    // Work carried down the divider pipeline for one item.
    typedef struct packed {
        logic [HUE_BITS-1:0]  hue_rem;
        logic [HUE_BITS-1:0]  hue_div;
        logic [FRAC_BITS-1:0] hue_quo;
        logic [COMP_BITS-1:0] sat_rem;
        logic [COMP_BITS-1:0] sat_div;
        logic [FRAC_BITS-1:0] sat_quo;
        logic                 sat_full;
        logic [COMP_BITS-1:0] value;
        logic                 gray;
    } t_div_state;

endpackage

// ===== design/rhc_front.sv =====
// Front end of the converter: max, min, delta and the hue sector numerator.
// Pure combinational logic; depends on rhc_pkg.
module rhc_front
    import rhc_pkg::*;
(
    input  t_rgb_in    i_pix,
    output t_div_state o_state
);

    logic [COMP_BITS-1:0] r, g, b;
    logic [COMP_BITS-1:0] mx, mn, delta;
    logic [HUE_BITS-1:0]  dw, num;

    assign r = i_pix.red_level;
    assign g = i_pix.green_level;
    assign b = i_pix.blue_level;

    always_comb begin
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
    end

    assign delta = mx - mn;
    assign dw    = HUE_BITS'(delta);

    // Red wins ties over green, green over blue. All sums stay nonnegative,
    // so the modular arithmetic at this width gives the exact numerator.
    always_comb begin
        if (r >= mx) begin
            if (g >= b) num = HUE_BITS'(g) - HUE_BITS'(b);
            else        num = (dw << 2) + (dw << 1) - (HUE_BITS'(b) - HUE_BITS'(g));
        end else if (g >= mx) begin
            num = (dw << 1) + HUE_BITS'(b) - HUE_BITS'(r);
        end else begin
            num = (dw << 2) + HUE_BITS'(r) - HUE_BITS'(g);
        end
    end

    always_comb begin
        o_state.hue_rem  = num;
        o_state.hue_div  = (dw << 2) + (dw << 1);
        o_state.hue_quo  = '0;
        o_state.sat_rem  = delta;
        o_state.sat_div  = mx;
        o_state.sat_quo  = '0;
        o_state.sat_full = (mn == '0);
        o_state.value    = mx;
        o_state.gray     = (delta == '0);
    end

endmodule

// ===== design/rhc_div_stage.sv =====
// One registered stage of the two fractional restoring dividers (hue and
// saturation), resolving DIV_STEP_BITS quotient bits of each. Uses rhc_pkg.
module rhc_div_stage
    import rhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_div_state i_state,
    output logic       o_valid,
    output t_div_state o_state
);

    t_div_state n_state;
    t_div_state r_state;
    logic       r_valid;

    // For a non-gray pixel with a nonzero minimum the remainder is below the
    // divisor, so each step shifts it left and subtracts the divisor once if it fits.
    always_comb begin
        logic [HUE_BITS:0]  hue_sh;
        logic [COMP_BITS:0] sat_sh;
        n_state = i_state;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            hue_sh = {n_state.hue_rem, 1'b0};
            if (hue_sh >= {1'b0, n_state.hue_div}) begin
                n_state.hue_rem = HUE_BITS'(hue_sh - {1'b0, n_state.hue_div});
                n_state.hue_quo = {n_state.hue_quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                n_state.hue_rem = HUE_BITS'(hue_sh);
                n_state.hue_quo = {n_state.hue_quo[FRAC_BITS-2:0], 1'b0};
            end
            sat_sh = {n_state.sat_rem, 1'b0};
            if (sat_sh >= {1'b0, n_state.sat_div}) begin
                n_state.sat_rem = COMP_BITS'(sat_sh - {1'b0, n_state.sat_div});
                n_state.sat_quo = {n_state.sat_quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                n_state.sat_rem = COMP_BITS'(sat_sh);
                n_state.sat_quo = {n_state.sat_quo[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

// ===== design/rgb_to_hsv_convert.sv =====
// Top level of the RGB to HSV converter: front end, divider pipeline and
// output register. Depends on rhc_pkg, rhc_front and rhc_div_stage.
//
// Usage:
//   Input channel i_pix / i_valid / o_stall takes one pixel item; output
//   channel o_hsv / o_valid / i_stall delivers one result item per pixel,
//   in order. An item moves at a clock edge where valid is high and stall
//   is low.
//   The pipeline holds one front register, one register per four quotient
//   bits of the two dividers, and the output register. Throughput is one
//   item per cycle while the receiver does not stall.
//   The pipeline moves as a whole: when the output holds an item and the
//   receiver stalls, every stage holds and o_stall is raised; empty slots
//   never block the input. Nothing is lost or repeated.
//   Reset (synchronous, active low) clears every valid bit; no item is in
//   flight afterwards. Gray pixels give zero hue and saturation and set
//   is_gray.
module rgb_to_hsv_convert
    import rhc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_rgb_in  i_pix,
    output logic     o_stall,
    output logic     o_valid,
    output t_hsv_out o_hsv,
    input  logic     i_stall
);

    logic       en;
    t_div_state front_state;
    t_div_state r_front;
    logic       r_front_valid;
    logic       stg_valid [DIV_STAGES+1];
    t_div_state stg_state [DIV_STAGES+1];
    t_hsv_out   n_hsv;
    t_hsv_out   r_hsv;
    logic       r_valid;

    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    rhc_front u_front (
        .i_pix   (i_pix),
        .o_state (front_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (en) begin
            r_front_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_front <= front_state;
        end
    end

    assign stg_valid[0] = r_front_valid;
    assign stg_state[0] = r_front;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        rhc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[s]),
            .i_state (stg_state[s]),
            .o_valid (stg_valid[s+1]),
            .o_state (stg_state[s+1])
        );
    end

    always_comb begin
        n_hsv.value_level = stg_state[DIV_STAGES].value;
        n_hsv.is_gray     = stg_state[DIV_STAGES].gray;
        if (stg_state[DIV_STAGES].gray) begin
            n_hsv.hue_turn        = '0;
            n_hsv.saturation_frac = '0;
        end else begin
            n_hsv.hue_turn = stg_state[DIV_STAGES].hue_quo;
            // A zero minimum means saturation of exactly one, clipped to all ones.
            if (stg_state[DIV_STAGES].sat_full) n_hsv.saturation_frac = '1;
            else n_hsv.saturation_frac = stg_state[DIV_STAGES].sat_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= stg_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hsv <= n_hsv;
        end
    end

    assign o_valid = r_valid;
    assign o_hsv   = r_hsv;

    a_gray_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsv.is_gray) |-> (o_hsv.hue_turn == '0 && o_hsv.saturation_frac == '0))
        else $error("gray item with nonzero hue or saturation");

    a_color_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hsv.is_gray) |-> (o_hsv.value_level != '0 && o_hsv.saturation_frac != '0))
        else $error("colored item with zero value or saturation");

    a_out_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall))
        else $error("output item dropped while stalled");

endmodule

// ===== dv/rgb_to_hsv_convert_test.sv =====
// Self-checking testbench for rgb_to_hsv_convert: directed and random pixels,
// with every result predicted in place. Depends on rhc_pkg and the block's RTL.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_test;
    import rhc_pkg::*;

    localparam int          GAP_MAX      = 17;
    localparam int          PIPE_LATENCY = 2 + DIV_STAGES;
    localparam int unsigned FRAC_FULL    = (1 << FRAC_BITS) - 1;
    localparam int          RUN_LIMIT_NS = 600000;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    t_rgb_in  i_pix;
    logic     o_stall;
    logic     o_valid;
    t_hsv_out o_hsv;
    logic     i_stall;

    t_hsv_out hsv_expected[$];
    t_hsv_out oldest_hsv;
    int       error_count = 0;
    bit       tx_steady   = 1'b0;
    bit       rx_steady   = 1'b0;

    rgb_to_hsv_convert dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pix   (i_pix),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_hsv   (o_hsv),
        .i_stall (i_stall)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_hsv_out predict_hsv(input t_rgb_in px);
        int unsigned r, g, b, top, bottom, delta, num, sat, hue_q;
        t_hsv_out    res;
        r      = px.red_level;
        g      = px.green_level;
        b      = px.blue_level;
        top    = (r > g) ? r : g;
        top    = (b > top) ? b : top;
        bottom = (r < g) ? r : g;
        bottom = (b < bottom) ? b : bottom;
        delta  = top - bottom;
        res    = '0;
        res.value_level = top[COMP_BITS-1:0];
        if (delta == 0) begin
            res.is_gray = 1'b1;
            return res;
        end
        sat = (delta << FRAC_BITS) / top;
        if (sat > FRAC_FULL) begin
            sat = FRAC_FULL;
        end
        // Ties for the maximum go to red first, then green.
        if (r == top) begin
            num = (g >= b) ? g - b : 6 * delta - (b - g);
        end else if (g == top) begin
            num = 2 * delta + b - r;
        end else begin
            num = 4 * delta + r - g;
        end
        hue_q = (num << FRAC_BITS) / (6 * delta);
        res.hue_turn        = hue_q[FRAC_BITS-1:0];
        res.saturation_frac = sat[FRAC_BITS-1:0];
        return res;
    endfunction

    // Drives one pixel after a random gap and returns once it is taken.
    task automatic send_rgb(input int unsigned r, input int unsigned g, input int unsigned b);
        int      gap;
        t_rgb_in px;
        if ($urandom_range(0, 63) == 0) begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        px.red_level   = r[COMP_BITS-1:0];
        px.green_level = g[COMP_BITS-1:0];
        px.blue_level  = b[COMP_BITS-1:0];
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= px;
        do @(posedge i_clk); while (o_stall);
        hsv_expected.push_back(predict_hsv(px));
    endtask

    // Stops sending and waits for every outstanding result item.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_extreme_level();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return 254;
            3:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic test_directed_cases();
        send_rgb(0, 0, 0);          // black
        send_rgb(255, 255, 255);    // white
        send_rgb(128, 128, 128);    // mid gray
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 255, 0);      // red and green tie
        send_rgb(0, 255, 255);      // green and blue tie
        send_rgb(255, 0, 255);      // red and blue tie
        send_rgb(255, 0, 1);        // red sector, hue wraps past zero
        send_rgb(255, 1, 0);
        send_rgb(200, 100, 50);
        send_rgb(1, 0, 0);
        send_rgb(0, 1, 0);
        send_rgb(0, 0, 1);
        send_rgb(255, 254, 254);
        send_rgb(254, 255, 255);
        send_rgb(1, 1, 0);
        send_rgb(128, 64, 200);
        send_rgb(170, 85, 255);
    endtask

    task automatic test_uniform_pixels();
        repeat (600) begin
            send_rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end
    endtask

    // Pixels close to gray, often with two components tied.
    task automatic test_near_gray_pixels();
        int base, lvl[3], k;
        repeat (300) begin
            base = $urandom_range(0, 255);
            for (k = 0; k < 3; k++) begin
                lvl[k] = base + $urandom_range(0, 4) - 2;
                if (lvl[k] < 0) lvl[k] = 0;
                if (lvl[k] > 255) lvl[k] = 255;
            end
            case ($urandom_range(0, 3))
                1:       lvl[1] = lvl[0];
                2:       lvl[2] = lvl[1];
                3:       lvl[2] = lvl[0];
                default: ;
            endcase
            send_rgb(lvl[0], lvl[1], lvl[2]);
        end
    endtask

    task automatic test_extreme_levels();
        repeat (230) begin
            send_rgb(pick_extreme_level(), pick_extreme_level(), pick_extreme_level());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (hsv_expected.size() == 0) begin
                $error("result item with none expected: hue_turn=%0d value_level=%0d",
                       o_hsv.hue_turn, o_hsv.value_level);
                error_count++;
            end else begin
                oldest_hsv = hsv_expected.pop_front();
                if (o_hsv.hue_turn !== oldest_hsv.hue_turn) begin
                    $error("hue_turn expected %0d actual %0d",
                           oldest_hsv.hue_turn, o_hsv.hue_turn);
                    error_count++;
                end
                if (o_hsv.saturation_frac !== oldest_hsv.saturation_frac) begin
                    $error("saturation_frac expected %0d actual %0d",
                           oldest_hsv.saturation_frac, o_hsv.saturation_frac);
                    error_count++;
                end
                if (o_hsv.value_level !== oldest_hsv.value_level) begin
                    $error("value_level expected %0d actual %0d",
                           oldest_hsv.value_level, o_hsv.value_level);
                    error_count++;
                end
                if (o_hsv.is_gray !== oldest_hsv.is_gray) begin
                    $error("is_gray expected %0d actual %0d",
                           oldest_hsv.is_gray, o_hsv.is_gray);
                    error_count++;
                end
            end
        end
    end

    // The receiver may stall before taking each item; in steady mode it never stalls.
    initial begin
        int stall_len;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                rx_steady = !rx_steady;
            end
            stall_len = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
            @(negedge i_clk);
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pix   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        drain_results();
        test_uniform_pixels();
        drain_results();
        test_near_gray_pixels();
        test_extreme_levels();
        drain_results();
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
